// ===== rtl/core/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: segment table translator shared types and constants
// Op and status codes, entry layout, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ADDR_W           = 64;
  localparam int SIZE_W           = 32;
  localparam int PERM_W           = 3;
  localparam int SEG_IDX_W        = 4;
  localparam logic [ADDR_W-1:0] AUTO_GAP = 64'h0000_0000_0000_1024;

  typedef enum logic {
    OP_ALLOC  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TAKEN = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] seg_start;
    logic [ADDR_W-1:0] seg_end;
    logic [PERM_W-1:0] perms;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } stt_cmd_t;

  typedef struct packed {
    logic scan_done;
  } stt_stat_t;

endpackage

// ===== rtl/core/stt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_if: item channels of the segment table translator
// Request channel (alloc/lookup) and response channel, valid/ready.
// ----------------------------------------------------------------------------
interface stt_req_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [stt_pkg::ADDR_W-1:0] address;
  logic [stt_pkg::SIZE_W-1:0] seg_size;
  logic [stt_pkg::PERM_W-1:0] perm_bits;

  modport source (output valid, operation, address, seg_size, perm_bits, input ready);
  modport sink   (input valid, operation, address, seg_size, perm_bits, output ready);
endinterface

interface stt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [stt_pkg::ADDR_W-1:0]    result_address;
  logic [stt_pkg::SEG_IDX_W-1:0] segment_index;
  logic [stt_pkg::PERM_W-1:0]    found_perms;

  modport source (output valid, status, result_address, segment_index, found_perms,
                  input ready);
  modport sink   (input valid, status, result_address, segment_index, found_perms,
                  output ready);
endinterface

// ===== rtl/core/stt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/stt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ctrl: segment table translator controller
// Sequences accept, table scan and finish; owns the response valid flag.
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  stt_pkg::stt_stat_t stat,
  output stt_pkg::stt_cmd_t  cmd
);
  import stt_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        req_ready = !rst;
        cmd.load  = req_valid && !rst;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = slot_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/stt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_datapath: segment table translator datapath
// Item registers, segment RAM, pipelined scan compare, allocation
// counters and the response register.
// ----------------------------------------------------------------------------
module stt_datapath #(
  parameter int MAX_SEGMENTS = stt_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stt_pkg::stt_cmd_t             cmd,
  output stt_pkg::stt_stat_t            stat,
  input  logic                          operation,
  input  logic [stt_pkg::ADDR_W-1:0]    address,
  input  logic [stt_pkg::SIZE_W-1:0]    seg_size,
  input  logic [stt_pkg::PERM_W-1:0]    perm_bits,
  output logic [1:0]                    status,
  output logic [stt_pkg::ADDR_W-1:0]    result_address,
  output logic [stt_pkg::SEG_IDX_W-1:0] segment_index,
  output logic [stt_pkg::PERM_W-1:0]    found_perms
);
  import stt_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SEGMENTS);

  // item registers
  logic              op_r;
  logic              auto_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] size_r;
  logic [PERM_W-1:0] perm_r;

  // table state
  logic [CW-1:0]     used_count;
  logic [ADDR_W-1:0] next_base;

  // scan state
  logic [CW-1:0]     rd_idx;
  logic [IW-1:0]     chk_idx;
  logic              chk_vld;
  logic              found;
  logic [IW-1:0]     hit_idx;
  logic [ADDR_W-1:0] hit_off;
  logic [PERM_W-1:0] hit_perms;

  seg_entry_t        rd_entry;
  seg_entry_t        wr_entry;
  logic [ENTRY_W-1:0] rdata;
  logic              issue;
  logic              match;
  logic              commit;
  logic [ADDR_W-1:0] end_addr;

  logic [1:0]           res_status;
  logic [ADDR_W-1:0]    res_addr;
  logic [SEG_IDX_W-1:0] res_idx;
  logic [PERM_W-1:0]    res_perms;

  assign rd_entry = seg_entry_t'(rdata);
  assign match    = cmd.scan && chk_vld &&
                    (addr_r >= rd_entry.seg_start) && (addr_r < rd_entry.seg_end);
  assign issue    = cmd.scan && !auto_r && !match && (rd_idx < used_count);
  assign stat.scan_done = auto_r || match || (rd_idx == used_count);

  assign end_addr = base_r + ADDR_W'(size_r);
  assign commit   = cmd.finish && (op_r == OP_ALLOC) && !found &&
                    (used_count != FULL_COUNT);

  assign wr_entry.seg_start = base_r;
  assign wr_entry.seg_end   = end_addr;
  assign wr_entry.perms     = perm_r;

  stt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_seg_ram (
    .clk  (clk),
    .we   (commit),
    .waddr(used_count[IW-1:0]),
    .wdata(wr_entry),
    .re   (issue),
    .raddr(rd_idx[IW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    res_status = ST_OK;
    res_addr   = '0;
    res_idx    = '0;
    res_perms  = '0;
    if (op_r == OP_LOOKUP) begin
      if (found) begin
        res_addr  = hit_off;
        res_idx   = SEG_IDX_W'(hit_idx);
        res_perms = hit_perms;
      end else begin
        res_status = ST_MISS;
      end
    end else if (found) begin
      res_status = ST_TAKEN;
    end else if (used_count == FULL_COUNT) begin
      res_status = ST_FULL;
    end else begin
      res_addr  = base_r;
      res_idx   = SEG_IDX_W'(used_count);
      res_perms = perm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      next_base  <= '0;
      rd_idx     <= '0;
      chk_vld    <= 1'b0;
      found      <= 1'b0;
      auto_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r    <= operation;
        addr_r  <= address;
        size_r  <= seg_size;
        perm_r  <= perm_bits;
        auto_r  <= (operation == OP_ALLOC) && (address == '0);
        base_r  <= (address == '0) ? next_base + AUTO_GAP : address;
        found   <= 1'b0;
        rd_idx  <= '0;
        chk_vld <= 1'b0;
      end
      if (cmd.scan) begin
        rd_idx  <= rd_idx + CW'(issue);
        chk_vld <= issue;
        chk_idx <= rd_idx[IW-1:0];
        if (match) begin
          found     <= 1'b1;
          hit_idx   <= chk_idx;
          hit_off   <= addr_r - rd_entry.seg_start;
          hit_perms <= rd_entry.perms;
        end
      end
      if (commit) begin
        used_count <= used_count + CW'(1);
        next_base  <= end_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= res_status;
      result_address <= res_addr;
      segment_index  <= res_idx;
      found_perms    <= res_perms;
    end
  end

endmodule

// ===== rtl/core/segment_table_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_table_translator: base-and-bounds segment table
// Allocates segments in order and translates addresses to segment offsets.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per valid/ready handshake: operation (alloc or
//   lookup), address, seg_size and perm_bits. rsp returns exactly one
//   result item per request: status, result_address, segment_index and
//   found_perms, with all result fields zero on a failure status.
//   Timing: one request is worked at a time. A lookup or an alloc at a
//   given base scans the allocated segments until a match or the end of
//   the table; an auto-placed alloc skips the scan. The cost is set by the
//   scan, which reads one stored segment per cycle from the segment RAM
//   and compares it against the request address. After the scan ends, the
//   finish step registers the result onto rsp once the result register is free.
//   Reset (rst, synchronous) empties the table and clears the next base;
//   segment RAM contents are not cleared and are never read before written.
//   When rsp stalls, the result register holds and the next request is still
//   taken and scanned; it waits in the finish step until the register frees.
// ----------------------------------------------------------------------------
module segment_table_translator #(
  parameter int MAX_SEGMENTS = stt_pkg::MAX_SEGMENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  stt_req_if.sink   req,
  stt_rsp_if.source rsp
);
  import stt_pkg::*;

  stt_cmd_t  cmd;
  stt_stat_t stat;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stt_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (req.operation),
    .address       (req.address),
    .seg_size      (req.seg_size),
    .perm_bits     (req.perm_bits),
    .status        (rsp.status),
    .result_address(rsp.result_address),
    .segment_index (rsp.segment_index),
    .found_perms   (rsp.found_perms)
  );

endmodule
